// ===== design/rblb_pkg.sv =====
// ----------------------------------------------------------------------------
// rblb_pkg
// Shared types and constants for the ring bin load balancer.
// ----------------------------------------------------------------------------
package rblb_pkg;

  localparam int LOAD_W       = 24;
  localparam int BIN_W        = 10;
  localparam int RATIO_W      = 16;
  localparam int ACT_W        = 2;
  localparam int PROD_W       = LOAD_W + RATIO_W;
  localparam int DEF_NUM_BINS = 1024;

  localparam logic [LOAD_W-1:0]  LOAD_MAX    = '1;
  localparam logic [RATIO_W-1:0] MERGE_RESET = 16'd1399;
  localparam logic [RATIO_W-1:0] SPLIT_RESET = 16'd1050;

  localparam logic [ACT_W-1:0] ACT_NONE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MERGE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_EQUAL = 2'd2;

  // APB register indexes (paddr[2])
  localparam logic REG_MERGE = 1'b0;
  localparam logic REG_SPLIT = 1'b1;

  typedef enum logic [1:0] {SW_CLEAR, SW_SCAN, SW_LEFT, SW_RIGHT} sweep_kind_t;

  typedef enum logic [2:0] {
    WD_INC, WD_SUM, WD_HALF_LO, WD_HALF_HI, WD_EQ_HI, WD_EQ_LO
  } wdata_sel_t;

  typedef enum logic [2:0] {CAP_NONE, CAP_U, CAP_L, CAP_R, CAP_Z, CAP_X} cap_sel_t;

  typedef enum logic [1:0] {MUL_MERGE, MUL_BIN, MUL_NBR} mul_sel_t;

  typedef struct packed {
    logic        wr_en;
    wdata_sel_t  wd_sel;
    logic        rem_u;
    cap_sel_t    cap;
    logic        sw_start;
    sweep_kind_t sw_kind;
    logic        sw_up;
    logic        mul_en;
    mul_sel_t    mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              gt_merge;
    logic              lt_split;
    logic              le_split;
    logic              left_lighter;
    logic [LOAD_W-1:0] lmax;
    logic [LOAD_W-1:0] lmin;
  } dp_status_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [BIN_W-1:0] removed;
    logic [BIN_W-1:0] receiving;
    logic [BIN_W-1:0] split;
  } result_t;

endpackage

// ===== design/rblb_req_if.sv =====
// ----------------------------------------------------------------------------
// rblb_req_if
// Request channel: op and addressed bin, valid/ready.
// ----------------------------------------------------------------------------
interface rblb_req_if;
  import rblb_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [BIN_W-1:0] bin;

  modport source (output valid, op, bin, input ready);
  modport sink (input valid, op, bin, output ready);
endinterface

// ===== design/rblb_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rblb_rsp_if
// Response channel: action taken, bin indexes and load extremes.
// ----------------------------------------------------------------------------
interface rblb_rsp_if;
  import rblb_pkg::*;

  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BIN_W-1:0]  removed_bin;
  logic [BIN_W-1:0]  receiving_bin;
  logic [BIN_W-1:0]  split_bin;
  logic [LOAD_W-1:0] max_load;
  logic [LOAD_W-1:0] min_load;

  modport source (output valid, action, removed_bin, receiving_bin, split_bin,
                  max_load, min_load, input ready);
  modport sink (input valid, action, removed_bin, receiving_bin, split_bin,
                max_load, min_load, output ready);
endinterface

// ===== design/rblb_dp.sv =====
// ----------------------------------------------------------------------------
// rblb_dp
// Datapath: load memory, sweep engine (clear, scan, shifts), operand
// registers and the shared ratio multiplier.
// ----------------------------------------------------------------------------
module rblb_dp #(
  parameter int NUM_BINS = rblb_pkg::DEF_NUM_BINS,
  localparam int IW = $clog2(NUM_BINS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rblb_pkg::dp_cmd_t            cmd,
  input  logic [IW-1:0]                addr,
  input  logic [IW-1:0]                sw_first,
  input  logic [IW-1:0]                sw_last,
  input  logic [rblb_pkg::RATIO_W-1:0] merge_ratio,
  input  logic [rblb_pkg::RATIO_W-1:0] split_ratio,
  output rblb_pkg::dp_status_t         st,
  output logic [IW-1:0]                min_idx,
  output logic [IW-1:0]                max_idx
);
  import rblb_pkg::*;

  logic [LOAD_W-1:0] mem [NUM_BINS];
  logic [LOAD_W-1:0] rdata;
  logic [IW-1:0]     ra, wa;
  logic              we;
  logic [LOAD_W-1:0] wd;

  sweep_kind_t   kind;
  logic [IW-1:0] cur, last;
  logic          up, issuing, pend_valid;
  logic [IW-1:0] pend_addr;

  logic [LOAD_W-1:0] lu, ln_l, ln_r, lz, x, lmin, lmax;
  logic [PROD_W-1:0] prod;
  logic [RATIO_W-1:0] mul_a;
  logic [LOAD_W-1:0]  mul_b;

  logic [LOAD_W:0]   sum_rem, half_hi;
  logic [LOAD_W+1:0] eq_sum;
  logic              sweep_clr, sweep_mv;

  assign sweep_clr = issuing && (kind == SW_CLEAR);
  assign sweep_mv  = pend_valid && ((kind == SW_LEFT) || (kind == SW_RIGHT));

  assign sum_rem = {1'b0, lz} + {1'b0, (cmd.rem_u ? lu : lmin)};
  assign half_hi = {1'b0, x} + 1'b1;
  assign eq_sum  = {2'b00, lu} + {2'b00, lz} + 26'(cmd.wd_sel == WD_EQ_HI);

  always_comb begin
    ra = issuing ? cur : addr;
    we = sweep_clr || sweep_mv || cmd.wr_en;
    if (sweep_clr) begin
      wa = cur;
    end else if (pend_valid && kind == SW_LEFT) begin
      wa = pend_addr - 1'b1;
    end else if (pend_valid && kind == SW_RIGHT) begin
      wa = pend_addr + 1'b1;
    end else begin
      wa = addr;
    end
    if (sweep_clr) begin
      wd = '0;
    end else if (sweep_mv) begin
      wd = rdata;
    end else begin
      case (cmd.wd_sel)
        WD_INC:     wd = (lu == LOAD_MAX) ? lu : lu + 1'b1;
        WD_SUM:     wd = sum_rem[LOAD_W] ? LOAD_MAX : sum_rem[LOAD_W-1:0];
        WD_HALF_LO: wd = {1'b0, x[LOAD_W-1:1]};
        WD_HALF_HI: wd = half_hi[LOAD_W:1];
        WD_EQ_HI:   wd = eq_sum[LOAD_W:1];
        WD_EQ_LO:   wd = eq_sum[LOAD_W:1];
        default:    wd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  // sweep engine: one address issued per cycle, its data handled in the next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing    <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= issuing && (kind != SW_CLEAR);
      if (cmd.sw_start) begin
        issuing <= 1'b1;
      end else if (issuing && cur == last) begin
        issuing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= cur;
    if (cmd.sw_start) begin
      kind <= cmd.sw_kind;
      cur  <= sw_first;
      last <= sw_last;
      up   <= cmd.sw_up;
    end else if (issuing) begin
      cur <= up ? cur + 1'b1 : cur - 1'b1;
    end
    if (pend_valid && kind == SW_SCAN) begin
      if (pend_addr == '0 || rdata < lmin) begin
        lmin    <= rdata;
        min_idx <= pend_addr;
      end
      if (pend_addr == '0 || rdata > lmax) begin
        lmax    <= rdata;
        max_idx <= pend_addr;
      end
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    case (cmd.cap)
      CAP_U:   lu   <= rdata;
      CAP_L:   ln_l <= rdata;
      CAP_R:   ln_r <= rdata;
      CAP_Z:   lz   <= (ln_l < ln_r) ? ln_l : ln_r;
      CAP_X:   x    <= rdata;
      default: ;
    endcase
    if (cmd.wr_en && cmd.wd_sel == WD_INC) begin
      lu <= wd;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      MUL_MERGE: begin mul_a = merge_ratio; mul_b = lmin; end
      MUL_BIN:   begin mul_a = split_ratio; mul_b = lu; end
      MUL_NBR:   begin mul_a = split_ratio; mul_b = lz; end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  assign st.busy         = issuing || pend_valid;
  assign st.gt_merge     = PROD_W'({lu, 8'h00}) > prod;
  assign st.lt_split     = prod < PROD_W'({lmax, 8'h00});
  assign st.le_split     = {1'b0, prod} <= (PROD_W+1)'({lmax, 9'h000});
  assign st.left_lighter = ln_l < ln_r;
  assign st.lmax         = lmax;
  assign st.lmin         = lmin;

endmodule

// ===== design/rblb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rblb_ctrl
// Sequencer: after the reset clear, steps one request through reads, scans,
// ratio checks, merge/split shifts or equalization, and the closing scan.
// ----------------------------------------------------------------------------
module rblb_ctrl #(
  parameter int NUM_BINS = rblb_pkg::DEF_NUM_BINS,
  localparam int IW = $clog2(NUM_BINS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_op,
  input  logic [rblb_pkg::BIN_W-1:0] req_bin,
  output logic                       req_ready,
  input  logic                       out_free,
  input  rblb_pkg::dp_status_t       st,
  input  logic [IW-1:0]              min_idx,
  input  logic [IW-1:0]              max_idx,
  output rblb_pkg::dp_cmd_t          cmd,
  output logic [IW-1:0]              addr,
  output logic [IW-1:0]              sw_first,
  output logic [IW-1:0]              sw_last,
  output rblb_pkg::result_t          res,
  output logic                       res_load
);
  import rblb_pkg::*;

  localparam logic [IW-1:0] LAST   = IW'(NUM_BINS - 1);
  localparam logic [IW-1:0] PENULT = IW'(NUM_BINS - 2);

  typedef enum logic [4:0] {
    S_CLR, S_CLR_W, S_IDLE, S_RD_U, S_CAP_U, S_INC, S_SCAN, S_SCAN_W, S_MUL,
    S_CHK, S_RD_L, S_RD_R, S_CAP_R, S_PICK, S_MUL2, S_CHK2, S_EQ_HI, S_EQ_LO,
    S_MS_W, S_MS_L, S_MS_L_W, S_MS_RDX, S_MS_CAPX, S_MS_R, S_MS_R_W, S_MS_LO,
    S_MS_HI, S_FIN, S_FIN_W, S_DONE
  } state_t;

  state_t        state;
  logic          op;
  logic [IW-1:0] u, rem, heavy, hp, z, nl, nr;

  function automatic logic [IW-1:0] left_of(input logic [IW-1:0] c);
    return (c == '0) ? LAST : c - 1'b1;
  endfunction

  function automatic logic [IW-1:0] right_of(input logic [IW-1:0] c);
    return (c == LAST) ? '0 : c + 1'b1;
  endfunction

  assign req_ready = (state == S_IDLE);
  assign res_load  = (state == S_DONE) && out_free;

  always_comb begin
    cmd      = '0;
    addr     = '0;
    sw_first = '0;
    sw_last  = '0;
    case (state)
      S_CLR: begin
        cmd.sw_start = 1'b1; cmd.sw_kind = SW_CLEAR; cmd.sw_up = 1'b1;
        sw_last = LAST;
      end
      S_RD_U:  addr = u;
      S_CAP_U: cmd.cap = CAP_U;
      S_INC:   begin cmd.wr_en = 1'b1; cmd.wd_sel = WD_INC; addr = u; end
      S_SCAN, S_FIN: begin
        cmd.sw_start = 1'b1; cmd.sw_kind = SW_SCAN; cmd.sw_up = 1'b1;
        sw_last = LAST;
      end
      S_MUL: begin cmd.mul_en = 1'b1; cmd.mul_sel = op ? MUL_BIN : MUL_MERGE; end
      S_RD_L:  addr = nl;
      S_RD_R:  begin addr = nr; cmd.cap = CAP_L; end
      S_CAP_R: cmd.cap = CAP_R;
      S_PICK:  cmd.cap = CAP_Z;
      S_MUL2:  begin cmd.mul_en = 1'b1; cmd.mul_sel = MUL_NBR; end
      S_EQ_HI: begin cmd.wr_en = 1'b1; cmd.wd_sel = WD_EQ_HI; addr = u; end
      S_EQ_LO: begin cmd.wr_en = 1'b1; cmd.wd_sel = WD_EQ_LO; addr = z; end
      S_MS_W: begin
        cmd.wr_en = 1'b1; cmd.wd_sel = WD_SUM; cmd.rem_u = op; addr = z;
      end
      S_MS_L: begin
        if (rem < LAST) begin
          cmd.sw_start = 1'b1; cmd.sw_kind = SW_LEFT; cmd.sw_up = 1'b1;
          sw_first = rem + 1'b1; sw_last = LAST;
        end
      end
      S_MS_RDX:  addr = hp;
      S_MS_CAPX: cmd.cap = CAP_X;
      S_MS_R: begin
        if (hp < PENULT) begin
          cmd.sw_start = 1'b1; cmd.sw_kind = SW_RIGHT; cmd.sw_up = 1'b0;
          sw_first = PENULT; sw_last = hp + 1'b1;
        end
      end
      S_MS_LO: begin cmd.wr_en = 1'b1; cmd.wd_sel = WD_HALF_LO; addr = hp; end
      S_MS_HI: begin cmd.wr_en = 1'b1; cmd.wd_sel = WD_HALF_HI; addr = hp + 1'b1; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      case (state)
        S_CLR:   state <= S_CLR_W;
        S_CLR_W: if (!st.busy) state <= S_IDLE;
        S_IDLE: begin
          if (req_valid) begin
            op            <= req_op;
            u             <= IW'(req_bin);
            res           <= '0;
            state         <= (32'(req_bin) < 32'(NUM_BINS)) ? S_RD_U : S_FIN;
          end
        end
        S_RD_U:   state <= S_CAP_U;
        S_CAP_U:  state <= op ? S_SCAN : S_INC;
        S_INC:    state <= S_SCAN;
        S_SCAN:   state <= S_SCAN_W;
        S_SCAN_W: if (!st.busy) state <= S_MUL;
        S_MUL:    state <= S_CHK;
        S_CHK: begin
          if (!op && st.gt_merge && min_idx != u) begin
            rem   <= min_idx;
            heavy <= u;
            nl    <= left_of(min_idx);
            nr    <= right_of(min_idx);
            state <= S_RD_L;
          end else if (op && st.lt_split && max_idx != u) begin
            rem   <= u;
            heavy <= max_idx;
            nl    <= left_of(u);
            nr    <= right_of(u);
            state <= S_RD_L;
          end else begin
            state <= S_FIN;
          end
        end
        S_RD_L:  state <= S_RD_R;
        S_RD_R:  state <= S_CAP_R;
        S_CAP_R: state <= S_PICK;
        S_PICK: begin
          z             <= st.left_lighter ? nl : nr;
          res.receiving <= BIN_W'(st.left_lighter ? nl : nr);
          state         <= op ? S_MUL2 : S_MS_W;
        end
        S_MUL2:  state <= S_CHK2;
        S_CHK2:  state <= st.le_split ? S_MS_W : S_EQ_HI;
        S_EQ_HI: state <= S_EQ_LO;
        S_EQ_LO: begin
          res.action <= ACT_EQUAL;
          state      <= S_FIN;
        end
        S_MS_W: begin
          // heavy bin moves down one place if the removed bin lay below it
          hp    <= (rem < heavy) ? heavy - 1'b1 : heavy;
          state <= S_MS_L;
        end
        S_MS_L:    state <= (rem < LAST) ? S_MS_L_W : S_MS_RDX;
        S_MS_L_W:  if (!st.busy) state <= S_MS_RDX;
        S_MS_RDX:  state <= S_MS_CAPX;
        S_MS_CAPX: state <= S_MS_R;
        S_MS_R:    state <= (hp < PENULT) ? S_MS_R_W : S_MS_LO;
        S_MS_R_W:  if (!st.busy) state <= S_MS_LO;
        S_MS_LO:   state <= S_MS_HI;
        S_MS_HI: begin
          res.action  <= ACT_MERGE;
          res.removed <= BIN_W'(rem);
          res.split   <= BIN_W'(hp);
          state       <= S_FIN;
        end
        S_FIN:   state <= S_FIN_W;
        S_FIN_W: if (!st.busy) state <= S_DONE;
        S_DONE:  if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/ring_bin_load_balancer_core.sv =====
// ----------------------------------------------------------------------------
// ring_bin_load_balancer_core
// Ring of bin loads with merge/split and equalize balancing, APB ratios.
//
//   channel   dir  handshake      payload
//   req       in   valid/ready    op, bin
//   rsp       out  valid/ready    action, removed_bin, receiving_bin,
//                                 split_bin, max_load, min_load
//   apb       in   psel/penable   merge_ratio @0x0, split_ratio @0x4
//
// One request at a time. A request with no move runs two full scans
// through the single memory read port; merge/split adds the two shift
// sweeps and equalize adds a neighbour check and two writes. After reset
// a clearing pass runs before req.ready rises.
// A finished result waits in the rsp register while the next request is taken.
// ----------------------------------------------------------------------------
module ring_bin_load_balancer_core #(
  parameter int NUM_BINS = rblb_pkg::DEF_NUM_BINS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rblb_req_if.sink    req,
  rblb_rsp_if.source  rsp
);
  import rblb_pkg::*;

  localparam int IW = $clog2(NUM_BINS);

  logic [RATIO_W-1:0] merge_ratio, split_ratio;
  dp_cmd_t            cmd;
  dp_status_t         st;
  result_t            res;
  logic               res_load, out_free;
  logic [IW-1:0]      addr, sw_first, sw_last, min_idx, max_idx;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPLIT) ? 32'(split_ratio) : 32'(merge_ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_ratio <= MERGE_RESET;
      split_ratio <= SPLIT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_SPLIT) begin
        split_ratio <= pwdata[RATIO_W-1:0];
      end else begin
        merge_ratio <= pwdata[RATIO_W-1:0];
      end
    end
  end

  rblb_ctrl #(.NUM_BINS(NUM_BINS)) u_ctrl (
    .clk, .rst,
    .req_valid (req.valid),
    .req_op    (req.op),
    .req_bin   (req.bin),
    .req_ready (req.ready),
    .out_free, .st, .min_idx, .max_idx, .cmd, .addr, .sw_first, .sw_last,
    .res, .res_load
  );

  rblb_dp #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk, .rst, .cmd, .addr, .sw_first, .sw_last, .merge_ratio, .split_ratio,
    .st, .min_idx, .max_idx
  );

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp.action        <= res.action;
      rsp.removed_bin   <= res.removed;
      rsp.receiving_bin <= res.receiving;
      rsp.split_bin     <= res.split;
      rsp.max_load      <= st.lmax;
      rsp.min_load      <= st.lmin;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !st.busy)
    else $error("request taken while a sweep is running");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.action == ACT_NONE) |->
      (rsp.removed_bin == '0 && rsp.receiving_bin == '0 && rsp.split_bin == '0))
    else $error("indexes set on a result with no move");

  a_min_max: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.min_load <= rsp.max_load)
    else $error("min load above max load");

endmodule
